/* hdl/mjps_pkg.sv */
package mjps_pkg;

  // Sizes
  localparam int MAX_JOINTS    = 16;
  localparam int OUT_LIMIT     = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = 32;
  localparam int SPEED_W       = 16;
  localparam int KIND_W        = 2;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 5;
  localparam int MS_W          = 16;
  localparam int FUNC_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MOVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEFINE = 2'd2;

  // Joint kinds (kind three steps like a gripper)
  localparam logic [KIND_W-1:0] KIND_ROT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRP = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT  = 2'd1;

  // Reset values
  localparam logic [SPEED_W-1:0] GLOBAL_SPEED_RST = 16'd256;
  localparam logic [CNT_W-1:0]   JOINT_COUNT_RST  = 5'd1;
  localparam logic [SPEED_W-1:0] SPEED_RST        = 16'd256;

  // Distance per second for each kind, from Q8.24 rounded to POS_FRAC_BITS,
  // then split into quotient and remainder by 1000 (ms per second)
  localparam int BASE_SH = 24 - POS_FRAC_BITS;
  localparam logic [31:0] BASE_ROT =
    32'((32'd26353589 + ((32'd1 << BASE_SH) >> 1)) >> BASE_SH);
  localparam logic [31:0] BASE_TRN =
    32'((32'd503316480 + ((32'd1 << BASE_SH) >> 1)) >> BASE_SH);
  localparam logic [31:0] BASE_GRP =
    32'((32'd8388608 + ((32'd1 << BASE_SH) >> 1)) >> BASE_SH);

  localparam int QUO_W = 19;
  localparam int REM_W = 10;
  localparam logic [QUO_W-1:0] QUO_ROT = QUO_W'(BASE_ROT / 1000);
  localparam logic [REM_W-1:0] REM_ROT = REM_W'(BASE_ROT % 1000);
  localparam logic [QUO_W-1:0] QUO_TRN = QUO_W'(BASE_TRN / 1000);
  localparam logic [REM_W-1:0] REM_TRN = REM_W'(BASE_TRN % 1000);
  localparam logic [QUO_W-1:0] QUO_GRP = QUO_W'(BASE_GRP / 1000);
  localparam logic [REM_W-1:0] REM_GRP = REM_W'(BASE_GRP % 1000);

  // Exact divide by 1000 for a 26-bit dividend: (x * ceil(2^36/1000)) >> 36
  localparam int REMP_W    = 26;
  localparam int MAGIC_W   = 27;
  localparam int DIV_SHIFT = 36;
  localparam int DQ_W      = 17;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 27'd68719477;

  // Step datapath widths
  localparam int A_W   = 35;
  localparam int E_W   = 43;
  localparam int STP_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_TICK
  } state_t;

  // Static joint data, written by define only
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] low;
    logic signed [POS_W-1:0] high;
  } cfg_ent_t;

  // Motion state, rewritten by define, move and tick
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] goal;
    logic [SPEED_W-1:0]      speed;
    logic                    moving;
  } dyn_ent_t;

endpackage

/* hdl/multi_joint_position_slew_unit.sv */
// Define, and any rejected transaction: result in the cycle after start, busy stays low.
// Move: one memory read, then clamp and write-back; the result is registered from the write-back.
// Tick over n joints: the joint memory is read once per cycle into a 5-stage
//   step pipeline (divide-by-1000 and two speed multiplies), results stream one per cycle
//   from stage 5 through the result register. Results cannot be stalled by the receiver.
// Reset (synchronous, rst_n low): control, configuration registers and per-entry valid bits clear.
module multi_joint_position_slew_unit #(
  parameter int MAX_JOINTS = mjps_pkg::MAX_JOINTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mjps_pkg::FUNC_W-1:0]          in_func,
  input  logic [mjps_pkg::IDX_W-1:0]           in_joint_index,
  input  logic [mjps_pkg::MS_W-1:0]            in_tick_ms,
  input  logic signed [mjps_pkg::POS_W-1:0]    in_target_position,
  input  logic [mjps_pkg::SPEED_W-1:0]         in_joint_speed,
  input  logic [mjps_pkg::KIND_W-1:0]          in_joint_kind,
  input  logic signed [mjps_pkg::POS_W-1:0]    in_limit_low,
  input  logic signed [mjps_pkg::POS_W-1:0]    in_limit_high,
  input  logic signed [mjps_pkg::POS_W-1:0]    in_safe_position,
  // result channel
  output logic                                 out_valid,
  output logic [mjps_pkg::IDX_W-1:0]           out_joint,
  output logic signed [mjps_pkg::POS_W-1:0]    out_position,
  output logic                                 out_moving,
  output logic                                 out_accepted,
  output logic                                 out_all_idle,
  output logic                                 out_last,
  // configuration
  input  logic                                 cfg_we,
  input  logic [mjps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mjps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int CAP = (MAX_JOINTS < mjps_pkg::OUT_LIMIT) ? MAX_JOINTS : mjps_pkg::OUT_LIMIT;
  localparam logic [mjps_pkg::CNT_W-1:0] CAP_C = mjps_pkg::CNT_W'(CAP);
  localparam logic [mjps_pkg::CNT_W-1:0] ONE_C = mjps_pkg::CNT_W'(1);
  localparam mjps_pkg::dyn_ent_t DYN_RST = '{pos: '0, goal: '0,
                                             speed: mjps_pkg::SPEED_RST, moving: 1'b0};

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [mjps_pkg::SPEED_W-1:0] global_speed_r;
  logic [mjps_pkg::CNT_W-1:0]   joint_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_speed_r <= mjps_pkg::GLOBAL_SPEED_RST;
      joint_count_r  <= mjps_pkg::JOINT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mjps_pkg::REG_GLOBAL_SPEED: global_speed_r <= cfg_wdata;
        mjps_pkg::REG_JOINT_COUNT:  joint_count_r  <= cfg_wdata[mjps_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective joint count: zero acts as one, clipped to the table size and OUT_LIMIT
  logic [mjps_pkg::CNT_W-1:0] eff_cnt;
  always_comb begin
    eff_cnt = joint_count_r;
    if (joint_count_r == '0) eff_cnt = ONE_C;
    else if (joint_count_r > CAP_C) eff_cnt = CAP_C;
  end

  // ---------------------------------------------------------------------------
  // Control
  mjps_pkg::state_t state_r, state_nxt;

  logic accept, move_ok, def_ok, def_wr, imm_res, issue;
  logic s5_vld_r, s5_last_r;

  assign accept  = start && !busy;
  assign move_ok = {1'b0, in_joint_index} < eff_cnt;
  assign def_ok  = int'(in_joint_index) < MAX_JOINTS;
  assign def_wr  = accept && (in_func == mjps_pkg::FUNC_DEFINE) && def_ok;
  // results produced straight from the accepted transaction
  assign imm_res = accept && (in_func != mjps_pkg::FUNC_TICK)
                   && !((in_func == mjps_pkg::FUNC_MOVE) && move_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mjps_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    busy      = (state_r != mjps_pkg::ST_IDLE);
    unique case (state_r)
      mjps_pkg::ST_IDLE: begin
        if (start) begin
          if (in_func == mjps_pkg::FUNC_TICK) state_nxt = mjps_pkg::ST_TICK;
          else if ((in_func == mjps_pkg::FUNC_MOVE) && move_ok) state_nxt = mjps_pkg::ST_MOVE;
        end
      end
      mjps_pkg::ST_MOVE: state_nxt = mjps_pkg::ST_IDLE;
      mjps_pkg::ST_TICK: begin
        if (s5_vld_r && s5_last_r) state_nxt = mjps_pkg::ST_IDLE;
      end
      default: state_nxt = mjps_pkg::ST_IDLE;
    endcase
  end

  // transaction capture and tick sequencing
  logic [mjps_pkg::IDX_W-1:0]        mv_idx_r;
  logic signed [mjps_pkg::POS_W-1:0] mv_target_r;
  logic [mjps_pkg::SPEED_W-1:0]      mv_speed_r;
  logic [mjps_pkg::MS_W-1:0]         ms_r;
  logic [mjps_pkg::CNT_W-1:0]        n_r;
  logic [mjps_pkg::CNT_W-1:0]        rd_cnt_r;
  logic                              issue_done_r;
  logic                              idle_acc_r;
  logic                              s5_mv;

  assign issue = (state_r == mjps_pkg::ST_TICK) && !issue_done_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      mv_idx_r    <= in_joint_index;
      mv_target_r <= in_target_position;
      mv_speed_r  <= in_joint_speed;
      ms_r        <= in_tick_ms;
      n_r         <= eff_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r     <= '0;
      issue_done_r <= 1'b1;
      idle_acc_r   <= 1'b1;
    end else if (accept && (in_func == mjps_pkg::FUNC_TICK)) begin
      rd_cnt_r     <= '0;
      issue_done_r <= 1'b0;
      idle_acc_r   <= 1'b1;
    end else begin
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + ONE_C;
        if (rd_cnt_r == n_r - ONE_C) issue_done_r <= 1'b1;
      end
      if (s5_vld_r) idle_acc_r <= idle_acc_r & ~s5_mv;
    end
  end

  // ---------------------------------------------------------------------------
  // Joint memories: static data and motion state, one read and one write port each
  mjps_pkg::cfg_ent_t cfg_mem [MAX_JOINTS];
  mjps_pkg::dyn_ent_t dyn_mem [MAX_JOINTS];
  logic [MAX_JOINTS-1:0] cfg_vld_r, dyn_vld_r;

  logic [JW-1:0]      rd_addr;
  mjps_pkg::cfg_ent_t cfg_q_r, cfg_rd, cfg_wdata_m;
  mjps_pkg::dyn_ent_t dyn_q_r, dyn_rd, dyn_wdata_m;
  logic               cfg_qv_r, dyn_qv_r;
  logic               dyn_we;
  logic [JW-1:0]      dyn_waddr, cfg_waddr;

  assign rd_addr = (state_r == mjps_pkg::ST_TICK) ? JW'(rd_cnt_r) : JW'(in_joint_index);

  assign cfg_waddr   = JW'(in_joint_index);
  assign cfg_wdata_m = '{kind: in_joint_kind, low: in_limit_low, high: in_limit_high};

  always_ff @(posedge clk) begin
    if (def_wr) cfg_mem[cfg_waddr] <= cfg_wdata_m;
    cfg_q_r <= cfg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dyn_we) dyn_mem[dyn_waddr] <= dyn_wdata_m;
    dyn_q_r <= dyn_mem[rd_addr];
  end

  // entries never written read as their reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_vld_r <= '0;
      dyn_vld_r <= '0;
    end else begin
      if (def_wr) cfg_vld_r[cfg_waddr] <= 1'b1;
      if (dyn_we) dyn_vld_r[dyn_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cfg_qv_r <= cfg_vld_r[rd_addr];
    dyn_qv_r <= dyn_vld_r[rd_addr];
  end

  assign cfg_rd = cfg_qv_r ? cfg_q_r : '0;
  assign dyn_rd = dyn_qv_r ? dyn_q_r : DYN_RST;

  // ---------------------------------------------------------------------------
  // Move: clamp the goal into the limits (low first, high wins)
  logic signed [mjps_pkg::POS_W-1:0] mv_goal;
  always_comb begin
    mv_goal = mv_target_r;
    if (cfg_rd.low > mv_goal)  mv_goal = cfg_rd.low;
    if (cfg_rd.high < mv_goal) mv_goal = cfg_rd.high;
  end

  // ---------------------------------------------------------------------------
  // Tick pipeline
  logic                         s1_vld_r, s1_last_r;
  logic [mjps_pkg::IDX_W-1:0]   s1_idx_r;

  logic                         s2_vld_r, s2_last_r;
  logic                         s3_vld_r, s3_last_r;
  logic                         s4_vld_r, s4_last_r;

  logic [mjps_pkg::IDX_W-1:0]   s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;
  mjps_pkg::dyn_ent_t           s2_dyn_r, s3_dyn_r, s4_dyn_r, s5_dyn_r;

  logic [mjps_pkg::A_W-1:0]     s2_a_r, s3_a_r;
  logic [mjps_pkg::REMP_W-1:0]  s2_b_r;
  logic [mjps_pkg::DQ_W-1:0]    s3_c_r;
  logic [mjps_pkg::E_W-1:0]     s4_e_r;
  logic [mjps_pkg::STP_W-1:0]   s5_st_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // stage 1: kind -> base split; base * ms as quotient and remainder parts
  logic [mjps_pkg::QUO_W-1:0] k_quo;
  logic [mjps_pkg::REM_W-1:0] k_rem;
  always_comb begin
    case (cfg_rd.kind)
      mjps_pkg::KIND_ROT: begin
        k_quo = mjps_pkg::QUO_ROT;
        k_rem = mjps_pkg::REM_ROT;
      end
      mjps_pkg::KIND_TRN: begin
        k_quo = mjps_pkg::QUO_TRN;
        k_rem = mjps_pkg::REM_TRN;
      end
      default: begin
        k_quo = mjps_pkg::QUO_GRP;
        k_rem = mjps_pkg::REM_GRP;
      end
    endcase
  end

  // stage 2: remainder part divided by 1000 through the reciprocal
  logic [mjps_pkg::REMP_W+mjps_pkg::MAGIC_W-1:0] c_prod;
  assign c_prod = (mjps_pkg::REMP_W + mjps_pkg::MAGIC_W)'(s2_b_r)
                * (mjps_pkg::REMP_W + mjps_pkg::MAGIC_W)'(mjps_pkg::DIV_MAGIC);

  // stage 3: joint speed
  logic [mjps_pkg::A_W-1:0]                  d_sum;
  logic [mjps_pkg::A_W+mjps_pkg::SPEED_W-1:0] e_prod;
  assign d_sum  = s3_a_r + mjps_pkg::A_W'(s3_c_r);
  assign e_prod = (mjps_pkg::A_W + mjps_pkg::SPEED_W)'(d_sum)
                * (mjps_pkg::A_W + mjps_pkg::SPEED_W)'(s3_dyn_r.speed);

  // stage 4: global speed, saturate the step to 32 bits
  logic [mjps_pkg::E_W+mjps_pkg::SPEED_W-1:0] f_prod;
  assign f_prod = (mjps_pkg::E_W + mjps_pkg::SPEED_W)'(s4_e_r)
                * (mjps_pkg::E_W + mjps_pkg::SPEED_W)'(global_speed_r);

  always_ff @(posedge clk) begin
    s1_last_r <= (rd_cnt_r == n_r - ONE_C);
    s1_idx_r  <= rd_cnt_r[mjps_pkg::IDX_W-1:0];

    s2_last_r <= s1_last_r;
    s2_idx_r  <= s1_idx_r;
    s2_dyn_r  <= dyn_rd;
    s2_a_r    <= mjps_pkg::A_W'(k_quo) * mjps_pkg::A_W'(ms_r);
    s2_b_r    <= mjps_pkg::REMP_W'(k_rem) * mjps_pkg::REMP_W'(ms_r);

    s3_last_r <= s2_last_r;
    s3_idx_r  <= s2_idx_r;
    s3_dyn_r  <= s2_dyn_r;
    s3_a_r    <= s2_a_r;
    s3_c_r    <= c_prod[mjps_pkg::DIV_SHIFT +: mjps_pkg::DQ_W];

    s4_last_r <= s3_last_r;
    s4_idx_r  <= s3_idx_r;
    s4_dyn_r  <= s3_dyn_r;
    s4_e_r    <= e_prod[8 +: mjps_pkg::E_W];

    s5_last_r <= s4_last_r;
    s5_idx_r  <= s4_idx_r;
    s5_dyn_r  <= s4_dyn_r;
    s5_st_r   <= (|f_prod[mjps_pkg::E_W+mjps_pkg::SPEED_W-1:8+mjps_pkg::STP_W])
                 ? '1 : f_prod[8 +: mjps_pkg::STP_W];
  end

  // stage 5: step toward the goal or snap onto it
  logic signed [mjps_pkg::POS_W:0]   dp, dn;
  logic signed [mjps_pkg::POS_W+1:0] pd, pu;
  logic                              step_dn, step_up;
  logic signed [mjps_pkg::POS_W-1:0] s5_pos;

  always_comb begin
    dp = {s5_dyn_r.pos[mjps_pkg::POS_W-1], s5_dyn_r.pos}
       - {s5_dyn_r.goal[mjps_pkg::POS_W-1], s5_dyn_r.goal};
    dn = {s5_dyn_r.goal[mjps_pkg::POS_W-1], s5_dyn_r.goal}
       - {s5_dyn_r.pos[mjps_pkg::POS_W-1], s5_dyn_r.pos};
    step_dn = !dp[mjps_pkg::POS_W]
              && ({dp[mjps_pkg::POS_W-1:0], 1'b0} > {1'b0, s5_st_r});
    step_up = !dn[mjps_pkg::POS_W]
              && ({dn[mjps_pkg::POS_W-1:0], 1'b0} > {1'b0, s5_st_r});
    pd = {{2{s5_dyn_r.pos[mjps_pkg::POS_W-1]}}, s5_dyn_r.pos} - {2'b00, s5_st_r};
    pu = {{2{s5_dyn_r.pos[mjps_pkg::POS_W-1]}}, s5_dyn_r.pos} + {2'b00, s5_st_r};
    s5_mv = step_dn || step_up;
    if (step_dn) begin
      // only underflow is possible going down
      if (pd[mjps_pkg::POS_W+1:mjps_pkg::POS_W-1] != 3'b000
          && pd[mjps_pkg::POS_W+1:mjps_pkg::POS_W-1] != 3'b111)
        s5_pos = {1'b1, {(mjps_pkg::POS_W-1){1'b0}}};
      else
        s5_pos = pd[mjps_pkg::POS_W-1:0];
    end else if (step_up) begin
      if (pu[mjps_pkg::POS_W+1:mjps_pkg::POS_W-1] != 3'b000
          && pu[mjps_pkg::POS_W+1:mjps_pkg::POS_W-1] != 3'b111)
        s5_pos = {1'b0, {(mjps_pkg::POS_W-1){1'b1}}};
      else
        s5_pos = pu[mjps_pkg::POS_W-1:0];
    end else begin
      s5_pos = s5_dyn_r.goal;
    end
  end

  // ---------------------------------------------------------------------------
  // Motion state write port: define, move or tick write-back
  always_comb begin
    dyn_we      = 1'b0;
    dyn_waddr   = JW'(in_joint_index);
    dyn_wdata_m = '{pos: in_safe_position, goal: in_safe_position,
                    speed: mjps_pkg::SPEED_RST, moving: 1'b0};
    if (def_wr) begin
      dyn_we = 1'b1;
    end else if (state_r == mjps_pkg::ST_MOVE) begin
      dyn_we      = 1'b1;
      dyn_waddr   = JW'(mv_idx_r);
      dyn_wdata_m = '{pos: dyn_rd.pos, goal: mv_goal, speed: mv_speed_r,
                      moving: dyn_rd.moving};
    end else if (s5_vld_r) begin
      dyn_we      = 1'b1;
      dyn_waddr   = JW'(s5_idx_r);
      dyn_wdata_m = '{pos: s5_pos, goal: s5_dyn_r.goal, speed: s5_dyn_r.speed,
                      moving: s5_mv};
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  logic                              res_vld_nxt, res_mv_nxt, res_acc_nxt;
  logic                              res_idle_nxt, res_last_nxt;
  logic [mjps_pkg::IDX_W-1:0]        res_joint_nxt;
  logic signed [mjps_pkg::POS_W-1:0] res_pos_nxt;

  logic                              out_valid_r, out_moving_r, out_accepted_r;
  logic                              out_all_idle_r, out_last_r;
  logic [mjps_pkg::IDX_W-1:0]        out_joint_r;
  logic signed [mjps_pkg::POS_W-1:0] out_position_r;

  always_comb begin
    res_vld_nxt   = 1'b0;
    res_joint_nxt = in_joint_index;
    res_pos_nxt   = def_wr ? in_safe_position : '0;
    res_mv_nxt    = 1'b0;
    res_acc_nxt   = def_wr;
    res_idle_nxt  = 1'b0;
    res_last_nxt  = 1'b1;
    if (imm_res) begin
      res_vld_nxt = 1'b1;
    end else if (state_r == mjps_pkg::ST_MOVE) begin
      res_vld_nxt   = 1'b1;
      res_joint_nxt = mv_idx_r;
      res_pos_nxt   = dyn_rd.pos;
      res_mv_nxt    = dyn_rd.moving;
      res_acc_nxt   = 1'b1;
    end else if (s5_vld_r) begin
      res_vld_nxt   = 1'b1;
      res_joint_nxt = s5_idx_r;
      res_pos_nxt   = s5_pos;
      res_mv_nxt    = s5_mv;
      res_acc_nxt   = 1'b1;
      res_idle_nxt  = s5_last_r && idle_acc_r && !s5_mv;
      res_last_nxt  = s5_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= res_vld_nxt;
  end

  always_ff @(posedge clk) begin
    out_joint_r    <= res_joint_nxt;
    out_position_r <= res_pos_nxt;
    out_moving_r   <= res_mv_nxt;
    out_accepted_r <= res_acc_nxt;
    out_all_idle_r <= res_idle_nxt;
    out_last_r     <= res_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_joint    = out_joint_r;
  assign out_position = out_position_r;
  assign out_moving   = out_moving_r;
  assign out_accepted = out_accepted_r;
  assign out_all_idle = out_all_idle_r;
  assign out_last     = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks

  // tick pipeline only runs inside a tick
  a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r || s2_vld_r || s3_vld_r || s4_vld_r || s5_vld_r)
      |-> state_r == mjps_pkg::ST_TICK)
    else $error("tick pipeline active outside a tick");

  // the last joint written back ends the tick
  a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r && s5_last_r |=> state_r == mjps_pkg::ST_IDLE)
    else $error("tick did not finish after its last joint");

  // issue counter stays below the joint count while issuing
  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> rd_cnt_r < n_r)
    else $error("joint read issued beyond the count");

  // a rejected transaction reports a zero position and no motion
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_accepted_r |-> out_position_r == '0 && !out_moving_r)
    else $error("rejected result carries joint data");

  // define and move never share a write cycle with a tick write-back
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |-> !def_wr && state_r != mjps_pkg::ST_MOVE)
    else $error("conflicting motion state writes");

endmodule
